FILE: sv/ter_pkg.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer package
// Shared types, widths and screen defaults for the edge-function rasterizer.
// ----------------------------------------------------------------------------
package ter_pkg;

  localparam int ScreenWidthDef  = 64;
  localparam int ScreenHeightDef = 32;

  localparam int XW    = 6;
  localparam int YW    = 5;
  localparam int MaskW = 64;
  localparam int EdgeW = 15;
  localparam int OpAW  = 8;
  localparam int OpBW  = 7;

  typedef struct packed {
    logic [XW-1:0] vertex_a_x;
    logic [YW-1:0] vertex_a_y;
    logic [XW-1:0] vertex_b_x;
    logic [YW-1:0] vertex_b_y;
    logic [XW-1:0] vertex_c_x;
    logic [YW-1:0] vertex_c_y;
  } tri_t;

  typedef struct packed {
    logic [YW-1:0]    row_index;
    logic [MaskW-1:0] covered_columns;
    logic             last_row;
  } row_t;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StRows
  } state_e;

  typedef enum logic [1:0] {
    PhPq,
    PhQp,
    PhBase
  } phase_e;

endpackage

FILE: sv/triangle_edge_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer
// Results: after setup, one row result per cycle for each bounding-box row;
// the block stays busy with a triangle until its last row (or setup, if empty).
// Setup runs nine steps through one shared multiply-add unit; rows then step
// one per cycle with all columns tested side by side.
// Reset clears the sequencer and the result strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer_top #(
  parameter int SCREEN_WIDTH  = ter_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ter_pkg::ScreenHeightDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ter_pkg::tri_t tri_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output ter_pkg::row_t result_o
);

  localparam int EW = ter_pkg::EdgeW;
  localparam int XW = ter_pkg::XW;
  localparam int YW = ter_pkg::YW;

  ter_pkg::state_e state_q, state_d;
  ter_pkg::phase_e phase_q, phase_d;
  logic [1:0]      edge_q, edge_d;

  ter_pkg::tri_t   vtx_q;
  logic [XW-1:0]   left_q, right_q;
  logic [YW-1:0]   y_q, bottom_q;
  logic            empty_q;
  logic signed [EW-1:0] tmp_q;
  logic signed [EW-1:0] base_q [3];

  logic            valid_q;
  ter_pkg::row_t   res_q;

  logic            accept;
  logic            setup_done;
  logic            row_last;
  logic [XW-1:0]   in_left, in_right;
  logic [YW-1:0]   in_top, in_bottom, in_bot_clamp;

  logic signed [EW-1:0] a_ext [3];
  logic signed [EW-1:0] b_ext [3];
  logic [XW-1:0]   px, qx;
  logic [YW-1:0]   py, qy;
  logic signed [ter_pkg::OpAW-1:0] op_a;
  logic signed [ter_pkg::OpBW-1:0] op_b;
  logic signed [EW-1:0] op_c;
  logic signed [EW-1:0] mac;
  logic [ter_pkg::MaskW-1:0] row_mask;

  assign accept     = start_i && !busy_o;
  assign setup_done = (phase_q == ter_pkg::PhBase) && (edge_q == 2'd2);
  assign row_last   = (y_q == bottom_q);

  always_comb begin
    in_left = tri_i.vertex_a_x;
    if (tri_i.vertex_b_x < in_left) in_left = tri_i.vertex_b_x;
    if (tri_i.vertex_c_x < in_left) in_left = tri_i.vertex_c_x;
    in_right = tri_i.vertex_a_x;
    if (tri_i.vertex_b_x > in_right) in_right = tri_i.vertex_b_x;
    if (tri_i.vertex_c_x > in_right) in_right = tri_i.vertex_c_x;
    in_top = tri_i.vertex_a_y;
    if (tri_i.vertex_b_y < in_top) in_top = tri_i.vertex_b_y;
    if (tri_i.vertex_c_y < in_top) in_top = tri_i.vertex_c_y;
    in_bottom = tri_i.vertex_a_y;
    if (tri_i.vertex_b_y > in_bottom) in_bottom = tri_i.vertex_b_y;
    if (tri_i.vertex_c_y > in_bottom) in_bottom = tri_i.vertex_c_y;
    in_bot_clamp = in_bottom;
    if (int'(in_bottom) > SCREEN_HEIGHT - 1) in_bot_clamp = YW'(SCREEN_HEIGHT - 1);
  end

  // Edge coefficients: A = py - qy, B = qx - px for edges a->b, b->c, c->a.
  assign a_ext[0] = EW'(signed'({1'b0, vtx_q.vertex_a_y})) -
                    EW'(signed'({1'b0, vtx_q.vertex_b_y}));
  assign a_ext[1] = EW'(signed'({1'b0, vtx_q.vertex_b_y})) -
                    EW'(signed'({1'b0, vtx_q.vertex_c_y}));
  assign a_ext[2] = EW'(signed'({1'b0, vtx_q.vertex_c_y})) -
                    EW'(signed'({1'b0, vtx_q.vertex_a_y}));
  assign b_ext[0] = EW'(signed'({1'b0, vtx_q.vertex_b_x})) -
                    EW'(signed'({1'b0, vtx_q.vertex_a_x}));
  assign b_ext[1] = EW'(signed'({1'b0, vtx_q.vertex_c_x})) -
                    EW'(signed'({1'b0, vtx_q.vertex_b_x}));
  assign b_ext[2] = EW'(signed'({1'b0, vtx_q.vertex_a_x})) -
                    EW'(signed'({1'b0, vtx_q.vertex_c_x}));

  always_comb begin
    unique case (edge_q)
      2'd1: begin
        px = vtx_q.vertex_b_x; py = vtx_q.vertex_b_y;
        qx = vtx_q.vertex_c_x; qy = vtx_q.vertex_c_y;
      end
      2'd2: begin
        px = vtx_q.vertex_c_x; py = vtx_q.vertex_c_y;
        qx = vtx_q.vertex_a_x; qy = vtx_q.vertex_a_y;
      end
      default: begin
        px = vtx_q.vertex_a_x; py = vtx_q.vertex_a_y;
        qx = vtx_q.vertex_b_x; qy = vtx_q.vertex_b_y;
      end
    endcase
  end

  // Shared multiply-add: C = px*qy - qx*py, then base = B*top + C.
  always_comb begin
    unique case (phase_q)
      ter_pkg::PhQp: begin
        op_a = -signed'({2'b00, qx});
        op_b = signed'({2'b00, py});
        op_c = tmp_q;
      end
      ter_pkg::PhBase: begin
        op_a = b_ext[edge_q][ter_pkg::OpAW-1:0];
        op_b = signed'({2'b00, y_q});
        op_c = tmp_q;
      end
      default: begin
        op_a = signed'({2'b00, px});
        op_b = signed'({2'b00, qy});
        op_c = '0;
      end
    endcase
  end

  assign mac = EW'(op_a) * EW'(op_b) + op_c;

  for (genvar gx = 0; gx < ter_pkg::MaskW; gx++) begin : g_lane
    if (gx < SCREEN_WIDTH) begin : g_on
      logic signed [EW-1:0] e [3];
      logic in_box;
      for (genvar gk = 0; gk < 3; gk++) begin : g_edge
        assign e[gk] = base_q[gk] + a_ext[gk] * EW'(gx);
      end
      assign in_box = (int'(left_q) <= gx) && (gx <= int'(right_q));
      assign row_mask[gx] = in_box &&
                            ((!e[0][EW-1] && !e[1][EW-1] && !e[2][EW-1]) ||
                             (e[0][EW-1] && e[1][EW-1] && e[2][EW-1]));
    end else begin : g_off
      assign row_mask[gx] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    edge_d  = edge_q;
    unique case (state_q)
      ter_pkg::StIdle: begin
        if (accept) begin
          state_d = ter_pkg::StSetup;
          phase_d = ter_pkg::PhPq;
          edge_d  = 2'd0;
        end
      end
      ter_pkg::StSetup: begin
        unique case (phase_q)
          ter_pkg::PhPq:   phase_d = ter_pkg::PhQp;
          ter_pkg::PhQp:   phase_d = ter_pkg::PhBase;
          default: begin
            phase_d = ter_pkg::PhPq;
            edge_d  = edge_q + 2'd1;
          end
        endcase
        if (setup_done) begin
          state_d = empty_q ? ter_pkg::StIdle : ter_pkg::StRows;
        end
      end
      ter_pkg::StRows: begin
        if (row_last) state_d = ter_pkg::StIdle;
      end
      default: state_d = ter_pkg::StIdle;
    endcase
  end

  always_comb begin
    busy_o         = (state_q != ter_pkg::StIdle);
    result_valid_o = valid_q;
    result_o       = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ter_pkg::StIdle;
      phase_q <= ter_pkg::PhPq;
      edge_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      edge_q  <= edge_d;
      valid_q <= (state_q == ter_pkg::StRows);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vtx_q    <= tri_i;
      left_q   <= in_left;
      right_q  <= in_right;
      y_q      <= in_top;
      bottom_q <= in_bot_clamp;
      empty_q  <= (in_top > in_bot_clamp);
    end
    if (state_q == ter_pkg::StSetup) begin
      if (phase_q == ter_pkg::PhBase) begin
        base_q[edge_q] <= mac;
      end else begin
        tmp_q <= mac;
      end
    end
    if (state_q == ter_pkg::StRows) begin
      y_q       <= y_q + YW'(1);
      base_q[0] <= base_q[0] + b_ext[0];
      base_q[1] <= base_q[1] + b_ext[1];
      base_q[2] <= base_q[2] + b_ext[2];
      res_q.row_index       <= y_q;
      res_q.covered_columns <= row_mask;
      res_q.last_row        <= row_last;
    end
  end

  a_result_from_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ter_pkg::StRows))
    else $error("result strobe without a row step");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && state_q == ter_pkg::StSetup)
    else $error("start transfer did not enter setup");

  a_row_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_row |=>
      result_valid_o && result_o.row_index == $past(result_o.row_index) + YW'(1))
    else $error("row sequence broken");

  a_last_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_row |=> !result_valid_o)
    else $error("result after last row");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle edge rasterizer testbench
// Drives triangles through the start/busy handshake and checks every row
// result. The expected rows come from an independent edge-function model
// that is evaluated when each triangle is accepted. The run starts with
// fixed corner cases (full screen, both windings, collinear and coincident
// vertices, single pixels, screen edges) and then sends random triangles
// (mixed, small, collinear and extreme) with random gaps between them.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumRandom  = 340;
  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 60;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  ter_pkg::tri_t tri_i;
  logic busy_o;
  logic result_valid_o;
  ter_pkg::row_t result_o;

  ter_pkg::tri_t tri_backlog[$];
  ter_pkg::row_t rows_due[$];
  logic tri_taken;
  int   gap_left;
  int   calm_left;
  int   fail_count;
  int   idle_cycles;

  triangle_edge_rasterizer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .tri_i          (tri_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int edge_side(int px, int py, int qx, int qy, int x, int y);
    return (py - qy) * x + (qx - px) * y + (px * qy - qx * py);
  endfunction

  // Queue one result per bounding-box row of the triangle.
  function automatic void rasterize(ter_pkg::tri_t t);
    int ax, ay, bx, by, cx, cy;
    int lft, rgt, top, bot;
    int e0, e1, e2;
    logic [ter_pkg::MaskW-1:0] mask;
    ter_pkg::row_t r;
    ax = t.vertex_a_x;
    ay = t.vertex_a_y;
    bx = t.vertex_b_x;
    by = t.vertex_b_y;
    cx = t.vertex_c_x;
    cy = t.vertex_c_y;
    lft = (ax < bx) ? ax : bx;
    lft = (cx < lft) ? cx : lft;
    rgt = (ax > bx) ? ax : bx;
    rgt = (cx > rgt) ? cx : rgt;
    top = (ay < by) ? ay : by;
    top = (cy < top) ? cy : top;
    bot = (ay > by) ? ay : by;
    bot = (cy > bot) ? cy : bot;
    if (rgt > ter_pkg::ScreenWidthDef - 1) rgt = ter_pkg::ScreenWidthDef - 1;
    if (bot > ter_pkg::ScreenHeightDef - 1) bot = ter_pkg::ScreenHeightDef - 1;
    for (int y = top; y <= bot; y++) begin
      mask = '0;
      for (int x = lft; x <= rgt; x++) begin
        e0 = edge_side(ax, ay, bx, by, x, y);
        e1 = edge_side(bx, by, cx, cy, x, y);
        e2 = edge_side(cx, cy, ax, ay, x, y);
        if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 < 0 && e1 < 0 && e2 < 0)) begin
          mask[x] = 1'b1;
        end
      end
      r.row_index       = y[ter_pkg::YW-1:0];
      r.covered_columns = mask;
      r.last_row        = (y == bot);
      rows_due.push_back(r);
    end
  endfunction

  function automatic void add_tri(int ax, int ay, int bx, int by, int cx, int cy);
    ter_pkg::tri_t t;
    t.vertex_a_x = ax[ter_pkg::XW-1:0];
    t.vertex_a_y = ay[ter_pkg::YW-1:0];
    t.vertex_b_x = bx[ter_pkg::XW-1:0];
    t.vertex_b_y = by[ter_pkg::YW-1:0];
    t.vertex_c_x = cx[ter_pkg::XW-1:0];
    t.vertex_c_y = cy[ter_pkg::YW-1:0];
    tri_backlog.push_back(t);
  endfunction

  function automatic int corner_pick(int hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return hi - 1;
      default: return hi;
    endcase
  endfunction

  function automatic void add_random_tri();
    int ax, ay, dx, dy, k1, k2, kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      add_tri($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 63),
              $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 31));
    end else if (kind < 75) begin
      ax = $urandom_range(0, 58);
      ay = $urandom_range(0, 26);
      add_tri(ax + $urandom_range(0, 5), ay + $urandom_range(0, 5),
              ax + $urandom_range(0, 5), ay + $urandom_range(0, 5),
              ax + $urandom_range(0, 5), ay + $urandom_range(0, 5));
    end else if (kind < 90) begin
      // collinear or coincident vertices
      ax = $urandom_range(0, 63);
      ay = $urandom_range(0, 31);
      dx = $urandom_range(0, 8) - 4;
      dy = $urandom_range(0, 6) - 3;
      k1 = $urandom_range(0, 5);
      k2 = $urandom_range(0, 5);
      add_tri(ax, ay, ax + k1 * dx, ay + k1 * dy, ax - k2 * dx, ay - k2 * dy);
    end else begin
      add_tri(corner_pick(63), corner_pick(31), corner_pick(63),
              corner_pick(31), corner_pick(63), corner_pick(31));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void report_field(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s expected %h actual %h", $time, name, want, got);
    fail_count++;
  endfunction

  // Driver: hold the triangle until it is taken, then advance.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !tri_taken) begin
      end else if (gap_left > 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (tri_backlog.size() > 0) begin
        start_i  <= 1'b1;
        tri_i    <= tri_backlog.pop_front();
        gap_left <= pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check row results and predict rows for each taken triangle.
  always @(posedge clk_i) begin
    ter_pkg::row_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row result %h", $time, result_o);
          fail_count++;
        end else begin
          want = rows_due.pop_front();
          if (result_o.row_index !== want.row_index)
            report_field("row_index", 64'(want.row_index), 64'(result_o.row_index));
          if (result_o.covered_columns !== want.covered_columns)
            report_field("covered_columns", want.covered_columns,
                         result_o.covered_columns);
          if (result_o.last_row !== want.last_row)
            report_field("last_row", 64'(want.last_row), 64'(result_o.last_row));
        end
      end
      if (start_i && !busy_o) rasterize(tri_i);
      tri_taken <= start_i && !busy_o;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("triangle_edge_rasterizer_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    tri_i       = '0;
    tri_taken   = 1'b0;
    gap_left    = 0;
    calm_left   = 0;
    fail_count  = 0;
    idle_cycles = 0;

    add_tri(0, 0, 0, 0, 0, 0);
    add_tri(63, 31, 63, 31, 63, 31);
    add_tri(0, 0, 63, 0, 0, 31);
    add_tri(0, 0, 0, 31, 63, 0);
    add_tri(63, 31, 0, 31, 63, 0);
    add_tri(0, 0, 63, 31, 0, 31);
    add_tri(5, 10, 40, 10, 20, 10);
    add_tri(17, 0, 17, 31, 17, 12);
    add_tri(0, 0, 62, 31, 30, 15);
    add_tri(8, 8, 8, 8, 20, 25);
    add_tri(0, 31, 63, 31, 63, 30);
    add_tri(63, 0, 63, 0, 63, 0);
    add_tri(0, 31, 0, 31, 0, 31);
    add_tri(10, 31, 50, 31, 30, 31);
    add_tri(63, 0, 63, 31, 62, 15);
    add_tri(1, 1, 2, 1, 1, 2);
    add_tri(42, 21, 21, 10, 42, 10);
    add_tri(21, 10, 42, 21, 0, 31);
    add_tri(63, 0, 0, 31, 32, 15);
    add_tri(0, 0, 63, 31, 31, 15);
    repeat (NumRandom) add_random_tri();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (tri_backlog.size() > 0 || start_i) @(posedge clk_i);
    while (rows_due.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("triangle_edge_rasterizer_top: match");
    end else begin
      $display("triangle_edge_rasterizer_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ter_pkg.sv
sv/triangle_edge_rasterizer_top.sv
sim/tb.sv
